>>> hdl/psft_pkg.sv
// ----------------------------------------------------------------------------
// psft_pkg
// types and constants shared by the per-source flood throttle
// ----------------------------------------------------------------------------
package psft_pkg;

  localparam int TableEntries = 64;
  localparam int SlotW = $clog2(TableEntries);

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_DECAY    = 2'd1,
    REG_THROTTLE = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    OUT_DISABLED  = 3'd0,
    OUT_PASSED    = 3'd1,
    OUT_THROTTLED = 3'd2,
    OUT_ADDED     = 3'd3,
    OUT_FULL      = 3'd4
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK_RD,
    ST_LOOK_CMP,
    ST_HIT_DIV,
    ST_HIT_DONE,
    ST_ALLOC_RD,
    ST_ALLOC_EVAL,
    ST_ALLOC_DIV,
    ST_ALLOC_CHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] now_seconds;
    logic        is_ipv6;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } query_t;

  typedef struct packed {
    logic        blocked;
    logic [2:0]  outcome;
    logic [8:0]  bucket_level;
  } result_t;

endpackage

>>> hdl/per_source_flood_throttle.sv
// ----------------------------------------------------------------------------
// per_source_flood_throttle
// per-source leaky-bucket query limiter with a 64-slot source table
// ----------------------------------------------------------------------------
// One item at a time. A query reads the table one slot at a time looking
// for its address, then, on a hit, divides the elapsed time by decay_seconds in
// a shared 32-step restoring divider; a miss scans slots round robin and runs
// the divider on each valid slot. There is a single divider, and the table
// read has one port.
// Reset clears the valid bits at once, no clearing pass.
module per_source_flood_throttle
  import psft_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  query_t      in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        enable;
  logic [31:0] decay_seconds;
  logic [7:0]  throttle_limit;

  logic [TableEntries-1:0] entry_valid;
  logic [128:0] mem_key [TableEntries];
  logic [39:0]  mem_cnt [TableEntries];

  state_t state, state_next;
  query_t q;
  logic [128:0] q_key;
  logic [SlotW-1:0] slot, last_slot_used;
  logic [SlotW:0] steps;
  logic [128:0] rd_key;
  logic [7:0]   rd_cnt;
  logic [31:0]  rd_seen;
  logic         rd_valid;
  logic [31:0]  dividend, quo;
  logic [32:0]  rem;
  logic [5:0]   div_i;
  logic         wr_en;
  logic [39:0]  wr_cnt;
  logic         key_wr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      decay_seconds <= 32'd3;
      throttle_limit <= 8'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:   enable <= cfg_data[0];
        REG_DECAY:    decay_seconds <= cfg_data;
        REG_THROTTLE: throttle_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // table read, registered
  always_ff @(posedge clk) begin
    rd_key   <= mem_key[slot];
    {rd_cnt, rd_seen} <= mem_cnt[slot];
    rd_valid <= entry_valid[slot];
    if (wr_en) mem_cnt[slot] <= wr_cnt;
    if (key_wr) mem_key[slot] <= q_key;
  end

  // decayed count + 1 from quotient
  logic [8:0] dec_nc;
  always_comb begin
    dec_nc = (quo >= {24'd0, rd_cnt}) ? 9'd1 : ({1'b0, rd_cnt} - quo[8:0] + 9'd1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = enable ? ST_LOOK_RD : ST_OUT;
      ST_LOOK_RD:   state_next = ST_LOOK_CMP;
      ST_LOOK_CMP:
        if (rd_valid && rd_key == q_key) state_next = ST_HIT_DIV;
        else if (steps == TableEntries[SlotW:0] - 1'b1) state_next = ST_ALLOC_RD;
        else state_next = ST_LOOK_RD;
      ST_HIT_DIV:   if (div_i == 6'd32) state_next = ST_HIT_DONE;
      ST_HIT_DONE:  state_next = ST_OUT;
      ST_ALLOC_RD:  state_next = ST_ALLOC_EVAL;
      ST_ALLOC_EVAL:
        if (!rd_valid) state_next = ST_OUT;
        else state_next = ST_ALLOC_DIV;
      ST_ALLOC_DIV: if (div_i == 6'd32) state_next = ST_ALLOC_CHK;
      ST_ALLOC_CHK:
        if (dec_nc == 9'd1) state_next = ST_OUT;
        else if (steps == TableEntries[SlotW:0] - 1'b1) state_next = ST_OUT;
        else state_next = ST_ALLOC_RD;
      ST_OUT:       if (out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en  = 1'b0;
    key_wr = 1'b0;
    wr_cnt = {8'd1, q.now_seconds};
    if (state == ST_HIT_DONE && {1'b0, dec_nc} < {2'b0, throttle_limit}) begin
      wr_en = 1'b1;
      wr_cnt = {dec_nc[7:0], q.now_seconds};
    end
    if ((state == ST_ALLOC_EVAL && !rd_valid) ||
        (state == ST_ALLOC_CHK && dec_nc == 9'd1)) begin
      wr_en = 1'b1;
      key_wr = 1'b1;
    end
  end

  logic [32:0] trial;
  logic [31:0] dvs;
  assign dvs   = (decay_seconds == 32'd0) ? 32'd1 : decay_seconds;
  assign trial = {rem[31:0], dividend[31]} - {1'b0, dvs};

  // elapsed time of the slot just read during allocation
  logic [31:0] alloc_el;
  assign alloc_el = (q.now_seconds >= rd_seen) ? q.now_seconds - rd_seen : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      entry_valid <= '0;
      last_slot_used <= SlotW'(TableEntries - 1);
    end else begin
      state <= state_next;
      if (key_wr) begin
        entry_valid[slot] <= 1'b1;
        last_slot_used <= slot;
      end
    end
    unique case (state)
      ST_IDLE: begin
        q <= in_data;
        q_key <= {in_data.is_ipv6,
                  in_data.is_ipv6 ? in_data.address_high : 64'd0,
                  in_data.is_ipv6 ? in_data.address_low
                                  : {32'd0, in_data.address_low[31:0]}};
        slot <= '0;
        steps <= '0;
        if (!enable)
          out_data <= '{blocked: 1'b0, outcome: OUT_DISABLED, bucket_level: 9'd0};
      end
      ST_LOOK_RD: begin
        div_i <= '0;
      end
      ST_LOOK_CMP: begin
        dividend <= (q.now_seconds >= rd_seen) ? q.now_seconds - rd_seen : 32'd0;
        rem <= '0;
        div_i <= '0;
        if (!(rd_valid && rd_key == q_key)) begin
          if (steps == TableEntries[SlotW:0] - 1'b1) begin
            slot <= last_slot_used + 1'b1;
            steps <= '0;
          end else begin
            slot <= slot + 1'b1;
            steps <= steps + 1'b1;
          end
        end
      end
      ST_HIT_DIV, ST_ALLOC_DIV: begin
        if (div_i != 6'd32) begin
          if (!trial[32]) rem <= trial;
          else rem <= {rem[31:0], dividend[31]};
          quo <= {quo[30:0], ~trial[32]};
          dividend <= {dividend[30:0], 1'b0};
          div_i <= div_i + 1'b1;
        end
      end
      ST_HIT_DONE: begin
        out_data <= ({1'b0, dec_nc} >= {2'b0, throttle_limit}) ?
          '{blocked: 1'b1, outcome: OUT_THROTTLED, bucket_level: dec_nc} :
          '{blocked: 1'b0, outcome: OUT_PASSED, bucket_level: dec_nc};
      end
      ST_ALLOC_EVAL: begin
        dividend <= alloc_el;
        rem <= '0;
        div_i <= '0;
        if (!rd_valid)
          out_data <= '{blocked: 1'b0, outcome: OUT_ADDED, bucket_level: 9'd1};
      end
      ST_ALLOC_CHK: begin
        if (dec_nc == 9'd1)
          out_data <= '{blocked: 1'b0, outcome: OUT_ADDED, bucket_level: 9'd1};
        else if (steps == TableEntries[SlotW:0] - 1'b1)
          out_data <= '{blocked: 1'b1, outcome: OUT_FULL, bucket_level: 9'd0};
        else begin
          slot <= slot + 1'b1;
          steps <= steps + 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_one_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");
  a_full_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outcome == OUT_FULL |-> out_data.blocked)
    else $error("table full item not blocked");
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    key_wr |-> !in_ready)
    else $error("slot claimed while idle");
`endif

endmodule
